FILE: sv/mda_pkg.sv
// Package with the field widths, opcode and function codes and result type of the MIPS ALU.
package mda_pkg;

  localparam int WORD_W   = 32;
  localparam int REG_W    = 5;
  localparam int OPCODE_W = 6;
  localparam int FUNCT_W  = 6;
  localparam int SHAMT_W  = 5;
  localparam int IMM_W    = 16;

  localparam logic [OPCODE_W-1:0] OP_SPECIAL = 6'h00;
  localparam logic [OPCODE_W-1:0] OP_ADDI    = 6'h08;
  localparam logic [OPCODE_W-1:0] OP_ADDIU   = 6'h09;
  localparam logic [OPCODE_W-1:0] OP_SLTI    = 6'h0A;
  localparam logic [OPCODE_W-1:0] OP_SLTIU   = 6'h0B;
  localparam logic [OPCODE_W-1:0] OP_ANDI    = 6'h0C;
  localparam logic [OPCODE_W-1:0] OP_ORI     = 6'h0D;
  localparam logic [OPCODE_W-1:0] OP_XORI    = 6'h0E;
  localparam logic [OPCODE_W-1:0] OP_LUI     = 6'h0F;

  localparam logic [FUNCT_W-1:0] FN_SLL  = 6'h00;
  localparam logic [FUNCT_W-1:0] FN_SRL  = 6'h02;
  localparam logic [FUNCT_W-1:0] FN_ADD  = 6'h20;
  localparam logic [FUNCT_W-1:0] FN_ADDU = 6'h21;
  localparam logic [FUNCT_W-1:0] FN_SUB  = 6'h22;
  localparam logic [FUNCT_W-1:0] FN_SUBU = 6'h23;
  localparam logic [FUNCT_W-1:0] FN_AND  = 6'h24;
  localparam logic [FUNCT_W-1:0] FN_OR   = 6'h25;
  localparam logic [FUNCT_W-1:0] FN_XOR  = 6'h26;
  localparam logic [FUNCT_W-1:0] FN_NOR  = 6'h27;
  localparam logic [FUNCT_W-1:0] FN_SLT  = 6'h2A;
  localparam logic [FUNCT_W-1:0] FN_SLTU = 6'h2B;

  typedef struct packed {
    logic [WORD_W-1:0] alu_result;
    logic [REG_W-1:0]  dest_reg;
    logic              write_enable;
    logic              valid_op;
  } mda_result_t;

endpackage

FILE: sv/mda_if.sv
// Valid/ready channel interfaces for the instruction items and the result items.
interface mda_in_if;
  logic                        valid;
  logic                        ready;
  logic [mda_pkg::WORD_W-1:0]  instruction;
  logic [mda_pkg::WORD_W-1:0]  rs_value;
  logic [mda_pkg::WORD_W-1:0]  rt_value;

  modport source (output valid, output instruction, output rs_value, output rt_value,
                  input ready);
  modport sink (input valid, input instruction, input rs_value, input rt_value,
                output ready);
endinterface

interface mda_out_if;
  logic                        valid;
  logic                        ready;
  logic [mda_pkg::WORD_W-1:0]  alu_result;
  logic [mda_pkg::REG_W-1:0]   dest_reg;
  logic                        write_enable;
  logic                        valid_op;

  modport source (output valid, output alu_result, output dest_reg, output write_enable,
                  output valid_op, input ready);
  modport sink (input valid, input alu_result, input dest_reg, input write_enable,
                input valid_op, output ready);
endinterface

FILE: sv/mda_decode.sv
// Instruction decoder and integer ALU for one MIPS instruction word.
module mda_decode (
  input  logic [mda_pkg::WORD_W-1:0] instruction,
  input  logic [mda_pkg::WORD_W-1:0] rs_value,
  input  logic [mda_pkg::WORD_W-1:0] rt_value,
  output mda_pkg::mda_result_t       result
);
  import mda_pkg::*;

  logic [OPCODE_W-1:0] opcode;
  logic [REG_W-1:0]    rt;
  logic [REG_W-1:0]    rd;
  logic [SHAMT_W-1:0]  shamt;
  logic [FUNCT_W-1:0]  funct;
  logic [IMM_W-1:0]    imm;
  logic [WORD_W-1:0]   imm_sext;
  logic [WORD_W-1:0]   imm_zext;
  logic [WORD_W-1:0]   res;
  logic [REG_W-1:0]    dest;
  logic                ok;

  assign opcode   = instruction[31:26];
  assign rt       = instruction[20:16];
  assign rd       = instruction[15:11];
  assign shamt    = instruction[10:6];
  assign funct    = instruction[5:0];
  assign imm      = instruction[15:0];
  assign imm_sext = {{(WORD_W-IMM_W){imm[IMM_W-1]}}, imm};
  assign imm_zext = {{(WORD_W-IMM_W){1'b0}}, imm};

  always_comb begin
    res = '0;
    ok  = 1'b1;
    if (opcode == OP_SPECIAL) begin
      dest = rd;
      unique case (funct) inside
        FN_SLL:          res = rt_value << shamt;
        FN_SRL:          res = rt_value >> shamt;
        FN_ADD, FN_ADDU: res = rs_value + rt_value;
        FN_SUB, FN_SUBU: res = rs_value - rt_value;
        FN_AND:          res = rs_value & rt_value;
        FN_OR:           res = rs_value | rt_value;
        FN_XOR:          res = rs_value ^ rt_value;
        FN_NOR:          res = ~(rs_value | rt_value);
        FN_SLT:          res = {{(WORD_W-1){1'b0}}, $signed(rs_value) < $signed(rt_value)};
        FN_SLTU:         res = {{(WORD_W-1){1'b0}}, rs_value < rt_value};
        default:         ok = 1'b0;
      endcase
    end else begin
      dest = rt;
      unique case (opcode) inside
        OP_ADDI, OP_ADDIU: res = rs_value + imm_sext;
        OP_SLTI:  res = {{(WORD_W-1){1'b0}}, $signed(rs_value) < $signed(imm_sext)};
        OP_SLTIU: res = {{(WORD_W-1){1'b0}}, rs_value < imm_sext};
        OP_ANDI:  res = rs_value & imm_zext;
        OP_ORI:   res = rs_value | imm_zext;
        OP_XORI:  res = rs_value ^ imm_zext;
        OP_LUI:   res = {imm, {(WORD_W-IMM_W){1'b0}}};
        default:  ok = 1'b0;
      endcase
    end

    result.alu_result   = ok ? res : '0;
    result.dest_reg     = ok ? dest : '0;
    result.write_enable = ok;
    result.valid_op     = ok;
  end

endmodule

FILE: sv/mips_decode_and_integer_alu.sv
// Top level of the MIPS decode and integer ALU block with its input and result registers.
// The block takes one instruction item per clock cycle unless stalled, and returns one
// result item for each, in order: the item is captured in an input
// register, decoded and computed in one pass of logic, and held in a result register
// until the sink takes it. Unsupported opcodes and function codes give a result item
// with every field zero. Backpressure from the result side stalls the input side only
// when both registers are full.
module mips_decode_and_integer_alu (
  input  logic      clk,
  input  logic      rst_n,
  mda_in_if.sink    in_item,
  mda_out_if.source out_item
);
  import mda_pkg::*;

  logic              s1_v_r;
  logic              s1_v_nxt;
  logic [WORD_W-1:0] ins_r;
  logic [WORD_W-1:0] rs_r;
  logic [WORD_W-1:0] rt_r;
  logic              out_v_r;
  logic              out_v_nxt;
  mda_result_t       res_r;
  mda_result_t       dec_res;
  logic              out_take;
  logic              s1_adv;
  logic              in_acc;

  assign out_take     = !out_v_r || out_item.ready;
  assign s1_adv       = s1_v_r && out_take;
  assign in_item.ready = !s1_v_r || out_take;
  assign in_acc       = in_item.valid && in_item.ready;

  assign s1_v_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = s1_adv ? 1'b1 : (out_item.ready ? 1'b0 : out_v_r);

  mda_decode u_decode (
    .instruction (ins_r),
    .rs_value    (rs_r),
    .rt_value    (rt_r),
    .result      (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ins_r <= in_item.instruction;
      rs_r  <= in_item.rs_value;
      rt_r  <= in_item.rt_value;
    end
    if (s1_adv) begin
      res_r <= dec_res;
    end
  end

  assign out_item.valid        = out_v_r;
  assign out_item.alu_result   = res_r.alu_result;
  assign out_item.dest_reg     = res_r.dest_reg;
  assign out_item.write_enable = res_r.write_enable;
  assign out_item.valid_op     = res_r.valid_op;

endmodule

FILE: sv/mda_chk.sv
// Port checker for the MIPS decode and integer ALU and its bind to the top level.
module mda_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mda_pkg::WORD_W-1:0] out_alu_result,
  input logic [mda_pkg::REG_W-1:0]  out_dest_reg,
  input logic                       out_write_enable,
  input logic                       out_valid_op
);
  import mda_pkg::*;

  // A result is never shown in the cycle right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item valid right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result item dropped");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_alu_result) && $stable(out_dest_reg)
      && $stable(out_write_enable) && $stable(out_valid_op))
    else $error("stalled result item changed");

  a_we_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_write_enable == out_valid_op)
    else $error("write flag differs from supported flag");

  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_op |-> out_alu_result == '0 && out_dest_reg == '0)
    else $error("unsupported instruction gave a nonzero result");

endmodule

bind mips_decode_and_integer_alu mda_chk u_mda_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_item.valid),
  .out_ready        (out_item.ready),
  .out_alu_result   (out_item.alu_result),
  .out_dest_reg     (out_item.dest_reg),
  .out_write_enable (out_item.write_enable),
  .out_valid_op     (out_item.valid_op)
);

FILE: tb/mda_checker.sv
// Checker that predicts each result item of the MIPS ALU and compares it with the block's output.
`timescale 1ns / 1ps

module mda_checker (
  input  logic      clk,
  input  logic      rst_n,
  mda_in_if         in_ch,
  mda_out_if        out_ch,
  output int        fail_count,
  output int        pending_count
);
  import mda_pkg::*;

  mda_result_t expected_results[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic mda_result_t predict_alu(input logic [WORD_W-1:0] ins,
                                              input logic [WORD_W-1:0] a,
                                              input logic [WORD_W-1:0] b);
    mda_result_t        r;
    logic [OPCODE_W-1:0] opcode;
    logic [FUNCT_W-1:0]  funct;
    logic [SHAMT_W-1:0]  shamt;
    logic [IMM_W-1:0]    imm;
    logic [WORD_W-1:0]   imm_sext;
    logic [WORD_W-1:0]   imm_zext;
    logic                ok;
    opcode   = ins[31:26];
    shamt    = ins[10:6];
    funct    = ins[5:0];
    imm      = ins[15:0];
    imm_sext = {{16{imm[15]}}, imm};
    imm_zext = {16'h0000, imm};
    ok       = 1'b1;
    r.alu_result = '0;
    if (opcode == OP_SPECIAL) begin
      r.dest_reg = ins[15:11];
      case (funct) inside
        FN_SLL:           r.alu_result = b << shamt;
        FN_SRL:           r.alu_result = b >> shamt;
        FN_ADD, FN_ADDU:  r.alu_result = a + b;
        FN_SUB, FN_SUBU:  r.alu_result = a - b;
        FN_AND:           r.alu_result = a & b;
        FN_OR:            r.alu_result = a | b;
        FN_XOR:           r.alu_result = a ^ b;
        FN_NOR:           r.alu_result = ~(a | b);
        FN_SLT:           r.alu_result = {31'd0, $signed(a) < $signed(b)};
        FN_SLTU:          r.alu_result = {31'd0, a < b};
        default:          ok = 1'b0;
      endcase
    end else begin
      r.dest_reg = ins[20:16];
      case (opcode) inside
        OP_ADDI, OP_ADDIU: r.alu_result = a + imm_sext;
        OP_SLTI:           r.alu_result = {31'd0, $signed(a) < $signed(imm_sext)};
        OP_SLTIU:          r.alu_result = {31'd0, a < imm_sext};
        OP_ANDI:           r.alu_result = a & imm_zext;
        OP_ORI:            r.alu_result = a | imm_zext;
        OP_XORI:           r.alu_result = a ^ imm_zext;
        OP_LUI:            r.alu_result = {imm, 16'h0000};
        default:           ok = 1'b0;
      endcase
    end
    if (!ok) begin
      r.alu_result = '0;
      r.dest_reg   = '0;
    end
    r.write_enable = ok;
    r.valid_op     = ok;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    mda_result_t got;
    mda_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.alu_result   = out_ch.alu_result;
        got.dest_reg     = out_ch.dest_reg;
        got.write_enable = out_ch.write_enable;
        got.valid_op     = out_ch.valid_op;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result item with none expected, expected nothing, actual %h",
                   $time, got);
        end else begin
          want = expected_results.pop_front();
          report_field("alu_result", want.alu_result, got.alu_result);
          report_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
          report_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
          report_field("valid_op", 32'(want.valid_op), 32'(got.valid_op));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_alu(in_ch.instruction, in_ch.rs_value,
                                               in_ch.rt_value));
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

FILE: tb/tb_mips_decode_and_integer_alu.sv
// Testbench top that drives instruction items into the MIPS ALU and reports the verdict.
`timescale 1ns / 1ps

module tb_mips_decode_and_integer_alu;
  import mda_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int QUIET_TAIL   = 150;
  localparam int CYCLE_LIMIT  = 250000;

  localparam logic [OPCODE_W-1:0] OP_J    = 6'h02;
  localparam logic [OPCODE_W-1:0] OP_LW   = 6'h23;
  localparam logic [FUNCT_W-1:0]  FN_JR   = 6'h08;
  localparam logic [FUNCT_W-1:0]  FN_MOVN = 6'h0B;

  typedef struct {
    logic [WORD_W-1:0] ins;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_op_t;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   fail_count;
  int   pending_count;
  logic quiet;

  logic [FUNCT_W-1:0]  r_functs[12] = '{FN_SLL, FN_SRL, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
                                        FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
  logic [OPCODE_W-1:0] i_opcodes[8] = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI,
                                        OP_ORI, OP_XORI, OP_LUI};

  alu_op_t stimulus_q[$];

  mda_in_if  in_ch ();
  mda_out_if out_ch ();

  mips_decode_and_integer_alu dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  mda_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [WORD_W-1:0] make_r(input logic [FUNCT_W-1:0] funct,
                                               input logic [REG_W-1:0] rs,
                                               input logic [REG_W-1:0] rt,
                                               input logic [REG_W-1:0] rd,
                                               input logic [SHAMT_W-1:0] shamt);
    return {OP_SPECIAL, rs, rt, rd, shamt, funct};
  endfunction

  function automatic logic [WORD_W-1:0] make_i(input logic [OPCODE_W-1:0] opcode,
                                               input logic [REG_W-1:0] rs,
                                               input logic [REG_W-1:0] rt,
                                               input logic [IMM_W-1:0] imm);
    return {opcode, rs, rt, imm};
  endfunction

  function automatic alu_op_t op_of(input logic [WORD_W-1:0] ins,
                                    input logic [WORD_W-1:0] a,
                                    input logic [WORD_W-1:0] b);
    alu_op_t t;
    t.ins = ins;
    t.a   = a;
    t.b   = b;
    return t;
  endfunction

  function automatic logic [WORD_W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'($urandom_range(0, 15));
      default: return 32'($urandom());
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_reg();
    return REG_W'($urandom_range(0, 31));
  endfunction

  function automatic alu_op_t random_op();
    logic [WORD_W-1:0] word;
    int                kind;
    kind = $urandom_range(0, 99);
    word = 32'($urandom());
    if (kind < 45) begin
      word = make_r(r_functs[$urandom_range(0, 11)], pick_reg(), pick_reg(), pick_reg(),
                    SHAMT_W'($urandom_range(0, 31)));
    end else if (kind < 80) begin
      word = make_i(i_opcodes[$urandom_range(0, 7)], pick_reg(), pick_reg(),
                    IMM_W'($urandom_range(0, 65535)));
    end else if (kind < 90) begin
      word[31:26] = OP_SPECIAL;
    end
    return op_of(word, pick_operand(), pick_operand());
  endfunction

  task automatic send_item(input alu_op_t t);
    in_ch.valid       <= 1'b1;
    in_ch.instruction <= t.ins;
    in_ch.rs_value    <= t.a;
    in_ch.rt_value    <= t.b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_cycles(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    repeat (6) @(posedge clk);
    forever begin
      if (quiet) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    int total;
    int gap_odds;
    rst_n             <= 1'b0;
    quiet             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.instruction <= '0;
    in_ch.rs_value    <= '0;
    in_ch.rt_value    <= '0;
    gap_odds          = 0;

    // Directed items: field extremes, every operation and the corner cases.
    stimulus_q.push_back(op_of(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    stimulus_q.push_back(op_of(make_r(FN_SLL, 5'd31, 5'd31, 5'd31, 5'd31),
                               32'hFFFF_FFFF, 32'hFFFF_FFFF));
    stimulus_q.push_back(op_of(make_r(FN_SRL, 5'd0, 5'd1, 5'd2, 5'd31),
                               32'hFFFF_FFFF, 32'h8000_0000));
    stimulus_q.push_back(op_of(make_r(FN_SRL, 5'd3, 5'd4, 5'd5, 5'd0),
                               32'h0000_0000, 32'hFFFF_FFFF));
    stimulus_q.push_back(op_of(make_r(FN_ADD, 5'd1, 5'd2, 5'd3, 5'd0),
                               32'h7FFF_FFFF, 32'h0000_0001));
    stimulus_q.push_back(op_of(make_r(FN_ADDU, 5'd4, 5'd5, 5'd6, 5'd31),
                               32'hFFFF_FFFF, 32'hFFFF_FFFF));
    stimulus_q.push_back(op_of(make_r(FN_SUB, 5'd7, 5'd8, 5'd9, 5'd0),
                               32'h8000_0000, 32'h0000_0001));
    stimulus_q.push_back(op_of(make_r(FN_SUBU, 5'd10, 5'd11, 5'd12, 5'd0),
                               32'h0000_0000, 32'hFFFF_FFFF));
    stimulus_q.push_back(op_of(make_r(FN_AND, 5'd13, 5'd14, 5'd15, 5'd0),
                               32'hF0F0_F0F0, 32'hFFFF_0000));
    stimulus_q.push_back(op_of(make_r(FN_OR, 5'd16, 5'd17, 5'd18, 5'd0),
                               32'hF0F0_F0F0, 32'h0F0F_0000));
    stimulus_q.push_back(op_of(make_r(FN_XOR, 5'd19, 5'd20, 5'd21, 5'd0),
                               32'hFFFF_FFFF, 32'hAAAA_5555));
    stimulus_q.push_back(op_of(make_r(FN_NOR, 5'd22, 5'd23, 5'd24, 5'd0),
                               32'h0000_0000, 32'h0000_0000));
    stimulus_q.push_back(op_of(make_r(FN_SLT, 5'd25, 5'd26, 5'd27, 5'd0),
                               32'h8000_0000, 32'h0000_0001));
    stimulus_q.push_back(op_of(make_r(FN_SLTU, 5'd28, 5'd29, 5'd30, 5'd0),
                               32'h8000_0000, 32'h0000_0001));
    stimulus_q.push_back(op_of(make_i(OP_ADDI, 5'd1, 5'd2, 16'h8000),
                               32'h0000_0000, 32'hFFFF_FFFF));
    stimulus_q.push_back(op_of(make_i(OP_ADDIU, 5'd31, 5'd0, 16'hFFFF),
                               32'h0000_0000, 32'h0000_0000));
    stimulus_q.push_back(op_of(make_i(OP_SLTI, 5'd3, 5'd4, 16'h0000),
                               32'hFFFF_FFFF, 32'h0000_0000));
    stimulus_q.push_back(op_of(make_i(OP_SLTIU, 5'd5, 5'd6, 16'hFFFF),
                               32'h0000_0001, 32'h0000_0000));
    stimulus_q.push_back(op_of(make_i(OP_ANDI, 5'd7, 5'd8, 16'hFFFF),
                               32'hFFFF_FFFF, 32'h0000_0000));
    stimulus_q.push_back(op_of(make_i(OP_ORI, 5'd9, 5'd10, 16'h8000),
                               32'h0000_0000, 32'h0000_0000));
    stimulus_q.push_back(op_of(make_i(OP_XORI, 5'd11, 5'd31, 16'hFFFF),
                               32'hFFFF_FFFF, 32'h0000_0000));
    stimulus_q.push_back(op_of(make_i(OP_LUI, 5'd31, 5'd12, 16'hFFFF),
                               32'hFFFF_FFFF, 32'h0000_0000));
    stimulus_q.push_back(op_of(make_i(OP_LW, 5'd1, 5'd2, 16'h1234),
                               32'hFFFF_FFFF, 32'hFFFF_FFFF));
    stimulus_q.push_back(op_of(make_r(FN_JR, 5'd31, 5'd0, 5'd0, 5'd0),
                               32'hFFFF_FFFF, 32'hFFFF_FFFF));
    stimulus_q.push_back(op_of(make_r(FN_MOVN, 5'd1, 5'd2, 5'd3, 5'd0),
                               32'h0000_0001, 32'h0000_0001));
    stimulus_q.push_back(op_of(make_i(OP_J, 5'd31, 5'd31, 16'hFFFF),
                               32'h0000_0000, 32'h0000_0000));
    stimulus_q.push_back(op_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

    repeat (RANDOM_ITEMS) stimulus_q.push_back(random_op());
    total = stimulus_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < total; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       gap_odds = 0;
          1:       gap_odds = 2;
          2:       gap_odds = 4;
          default: gap_odds = 8;
        endcase
      end
      if (i == total - QUIET_TAIL) begin
        quiet <= 1'b1;
      end
      if (i == 700 || i == 1300) begin
        drain_results();
      end else if (i < total - QUIET_TAIL && gap_odds != 0 &&
                   $urandom_range(1, gap_odds) == 1) begin
        idle_cycles($urandom_range(1, 13));
      end
      send_item(stimulus_q[i]);
    end

    drain_results();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/mda_pkg.sv
sv/mda_if.sv
sv/mda_decode.sv
sv/mips_decode_and_integer_alu.sv
sv/mda_chk.sv
tb/mda_checker.sv
tb/tb_mips_decode_and_integer_alu.sv
